FILE: rtl/ssl_pkg.sv
// ----------------------------------------------------------------------------
// ssl_pkg
// Shared types and constants of the spline segment locator: field widths,
// command and status codes, configuration register indexes and defaults.
// ----------------------------------------------------------------------------
package ssl_pkg;

   localparam int DEF_MAX_KEYS   = 64;
   localparam int DEF_TIME_WIDTH = 32;

   localparam int KEY_INDEX_W = 6;
   localparam int START_W     = 8;
   localparam int SEGMENT_W   = 6;
   localparam int KEY_COUNT_W = 7;
   localparam int STATUS_W    = 2;
   localparam int CSR_DATA_W  = 7;

   localparam logic [KEY_COUNT_W-1:0] KEY_COUNT_RESET = 7'd2;
   localparam logic [KEY_COUNT_W-1:0] KEY_COUNT_MIN   = 7'd2;
   localparam int                     KEY_COUNT_TOP   = 127;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_QUERY = 1'b1
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_BEFORE = 2'd0,
      STATUS_DURING = 2'd1,
      STATUS_AFTER  = 2'd2
   } status_type;

   typedef enum logic {
      CSR_LOOP_ENABLE = 1'b0,
      CSR_KEY_COUNT   = 1'b1
   } csr_index_type;

endpackage

FILE: rtl/ssl_time_ram.sv
// ----------------------------------------------------------------------------
// ssl_time_ram
// Key time table: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ssl_time_ram #(
   parameter int DEPTH = ssl_pkg::DEF_MAX_KEYS,
   parameter int WIDTH = ssl_pkg::DEF_TIME_WIDTH,
   parameter int AW    = $clog2(ssl_pkg::DEF_MAX_KEYS)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/ssl_mod_unit.sv
// ----------------------------------------------------------------------------
// ssl_mod_unit
// Restoring remainder unit: one dividend bit per cycle, then done with the
// remainder of an unsigned dividend by an unsigned divisor.
// ----------------------------------------------------------------------------
module ssl_mod_unit #(
   parameter int WIDTH = ssl_pkg::DEF_TIME_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] remainder
);

   localparam int CW = $clog2(WIDTH + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [WIDTH-1:0] dvd_ff, dvd_in;
   logic [WIDTH-1:0] div_ff, div_in;
   logic [WIDTH:0]   rem_ff, rem_in;
   logic [WIDTH:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff[WIDTH-1:0], dvd_ff[WIDTH-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(WIDTH);
         dvd_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[WIDTH-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial - {1'b0, div_ff};
         end else begin
            rem_in = trial;
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[WIDTH-1:0];

endmodule

FILE: rtl/spline_segment_locator.sv
// ----------------------------------------------------------------------------
// spline_segment_locator
// Sorted key time table with a cursor search that returns the segment
// holding a query time, after wrapping or clamping the time.
// ----------------------------------------------------------------------------
// A req beat with tuser low writes key_time into table entry key_index and
// gives no rsp beat. A req beat with tuser high runs a
// query and gives one rsp beat with the status in tuser and the segment and
// mapped time in tdata. The csr port sets loop_enable and key_count; write
// it only while no query is in flight.
// A query reads the first and last keys, then in looping mode with a
// positive span runs the span remainder one bit per cycle, then walks the
// cursor with one table read (a read step and a compare step) for each
// crossed key and one or two more that end the walk, then loads the rsp
// register. How long a query runs is set by the remainder unit and the
// single read port; no new req beat is taken until the query is through.
// Reset empties the rsp register, returns to idle and sets loop_enable to 0
// and key_count to 2; the table is not cleared. A finished result waits in
// the rsp register while req beats are taken; a query that finishes while
// the register is still full holds until rsp_tready frees it.
// ----------------------------------------------------------------------------
module spline_segment_locator #(
   parameter int MAX_KEYS   = ssl_pkg::DEF_MAX_KEYS,
   parameter int TIME_WIDTH = ssl_pkg::DEF_TIME_WIDTH
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // key_index, key_time, query_time, start_segment
   input  logic [((ssl_pkg::KEY_INDEX_W + 2 * TIME_WIDTH + ssl_pkg::START_W + 7) / 8) * 8 - 1:0]
                req_tdata,
   // command
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // segment, mapped_time
   output logic [((ssl_pkg::SEGMENT_W + TIME_WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata,
   // status
   output logic [ssl_pkg::STATUS_W-1:0] rsp_tuser,
   input  logic csr_wr_en,
   input  logic csr_index,
   input  logic [ssl_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int TW     = TIME_WIDTH;
   localparam int KIW    = ssl_pkg::KEY_INDEX_W;
   localparam int NW     = ssl_pkg::KEY_COUNT_W;
   localparam int RSP_DW = ((ssl_pkg::SEGMENT_W + TIME_WIDTH + 7) / 8) * 8;
   localparam int AW     = $clog2(MAX_KEYS);
   localparam int IW     = (AW > KIW) ? AW : KIW;
   localparam int PW     = (AW > NW) ? AW : NW;
   localparam int NMAX   = (MAX_KEYS < ssl_pkg::KEY_COUNT_TOP) ? MAX_KEYS
                                                               : ssl_pkg::KEY_COUNT_TOP;

   typedef enum logic [9:0] {
      S_IDLE    = 10'b00_0000_0001,
      S_KEY0    = 10'b00_0000_0010,
      S_KEYN    = 10'b00_0000_0100,
      S_MAP     = 10'b00_0000_1000,
      S_WRAP    = 10'b00_0001_0000,
      S_FWD_RD  = 10'b00_0010_0000,
      S_FWD_CMP = 10'b00_0100_0000,
      S_BWD_RD  = 10'b00_1000_0000,
      S_BWD_CMP = 10'b01_0000_0000,
      S_DONE    = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic                  loop_ff, loop_in;
   logic [NW-1:0]         count_ff, count_in;

   logic                  req_accept;
   logic [KIW-1:0]        req_key_index;
   logic signed [TW-1:0]  req_key_time;
   logic signed [TW-1:0]  req_query_time;
   logic [ssl_pkg::START_W-1:0] req_start;

   logic [NW-1:0]         n_q;
   logic [NW-1:0]         start_q;
   logic [NW-1:0]         n_ff, n_in;
   logic [NW-1:0]         last_ff, last_in;
   logic [NW-1:0]         seg_ff, seg_in;
   logic signed [TW-1:0]  t_ff, t_in;
   logic signed [TW-1:0]  begin_ff, begin_in;
   logic [TW-1:0]         span_ff, span_in;
   logic                  neg_ff, neg_in;
   ssl_pkg::status_type   status_ff, status_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   ssl_pkg::status_type   rsp_status_ff, rsp_status_in;
   logic [ssl_pkg::SEGMENT_W-1:0] rsp_seg_ff, rsp_seg_in;
   logic [TW-1:0]         rsp_time_ff, rsp_time_in;

   logic [IW:0]           wr_idx;
   logic                  wr_en;
   logic [NW-1:0]         rd_sel;
   logic [PW-1:0]         rd_ext;
   logic [AW-1:0]         rd_addr;
   logic signed [TW-1:0]  rd_data;

   logic                  mod_start;
   logic [TW-1:0]         mod_dividend;
   logic                  mod_done;
   logic [TW-1:0]         mod_rem;
   logic [TW-1:0]         wrap_off;

   assign req_tready     = (state_ff == S_IDLE);
   assign req_accept     = req_tvalid && req_tready;
   assign req_key_index  = req_tdata[KIW-1:0];
   assign req_key_time   = req_tdata[KIW +: TW];
   assign req_query_time = req_tdata[KIW + TW +: TW];
   assign req_start      = req_tdata[KIW + 2 * TW +: ssl_pkg::START_W];

   assign wr_idx = (IW + 1)'(req_key_index);
   assign wr_en  = req_accept && (req_tuser == ssl_pkg::CMD_WRITE)
                   && (wr_idx < (IW + 1)'(MAX_KEYS));

   always_comb begin
      if (count_ff < ssl_pkg::KEY_COUNT_MIN) begin
         n_q = ssl_pkg::KEY_COUNT_MIN;
      end else if (count_ff > NW'(NMAX)) begin
         n_q = NW'(NMAX);
      end else begin
         n_q = count_ff;
      end
      if (req_start[ssl_pkg::START_W-1]) begin
         start_q = '0;
      end else if (req_start[NW-1:0] > n_q - NW'(2)) begin
         start_q = n_q - NW'(2);
      end else begin
         start_q = req_start[NW-1:0];
      end
   end

   always_comb begin
      unique case (state_ff)
         S_KEY0:   rd_sel = '0;
         S_KEYN:   rd_sel = n_ff - NW'(1);
         S_FWD_RD: rd_sel = seg_ff + NW'(1);
         default:  rd_sel = seg_ff;
      endcase
      rd_ext  = PW'(rd_sel);
      rd_addr = rd_ext[AW-1:0];
   end

   ssl_time_ram #(
      .DEPTH (MAX_KEYS),
      .WIDTH (TW),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx[AW-1:0]),
      .wr_data (req_key_time),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ssl_mod_unit #(
      .WIDTH (TW)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dividend),
      .divisor   (rd_data - begin_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign mod_dividend = (t_ff < begin_ff) ? (begin_ff - t_ff) : (t_ff - begin_ff);
   assign mod_start    = (state_ff == S_MAP) && loop_ff && (rd_data > begin_ff);
   assign wrap_off     = !neg_ff ? mod_rem
                                 : ((mod_rem != '0) ? (span_ff - mod_rem) : '0);

   always_comb begin
      loop_in       = loop_ff;
      count_in      = count_ff;
      state_in      = state_ff;
      n_in          = n_ff;
      last_in       = last_ff;
      seg_in        = seg_ff;
      t_in          = t_ff;
      begin_in      = begin_ff;
      span_in       = span_ff;
      neg_in        = neg_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_seg_in    = rsp_seg_ff;
      rsp_time_in   = rsp_time_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            ssl_pkg::CSR_LOOP_ENABLE: loop_in  = csr_wdata[0];
            ssl_pkg::CSR_KEY_COUNT:   count_in = csr_wdata[NW-1:0];
            default:                  count_in = count_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept && (req_tuser == ssl_pkg::CMD_QUERY)) begin
               n_in      = n_q;
               last_in   = n_q - NW'(2);
               seg_in    = start_q;
               t_in      = req_query_time;
               status_in = ssl_pkg::STATUS_DURING;
               state_in  = S_KEY0;
            end
         end
         S_KEY0: begin
            state_in = S_KEYN;
         end
         S_KEYN: begin
            begin_in = rd_data;
            state_in = S_MAP;
         end
         S_MAP: begin
            if (loop_ff) begin
               if (rd_data > begin_ff) begin
                  neg_in   = t_ff < begin_ff;
                  span_in  = rd_data - begin_ff;
                  state_in = S_WRAP;
               end else begin
                  t_in     = begin_ff;
                  state_in = S_FWD_RD;
               end
            end else begin
               if (t_ff > rd_data) begin
                  t_in = rd_data;
               end
               state_in = S_FWD_RD;
            end
         end
         S_WRAP: begin
            if (mod_done) begin
               t_in     = begin_ff + wrap_off;
               state_in = S_FWD_RD;
            end
         end
         S_FWD_RD: begin
            state_in = S_FWD_CMP;
         end
         S_FWD_CMP: begin
            if (t_ff >= rd_data) begin
               if (seg_ff == last_ff) begin
                  status_in = ssl_pkg::STATUS_AFTER;
                  state_in  = S_DONE;
               end else begin
                  seg_in   = seg_ff + NW'(1);
                  state_in = S_FWD_RD;
               end
            end else begin
               state_in = S_BWD_RD;
            end
         end
         S_BWD_RD: begin
            state_in = S_BWD_CMP;
         end
         S_BWD_CMP: begin
            if (t_ff < rd_data) begin
               if (seg_ff == '0) begin
                  status_in = ssl_pkg::STATUS_BEFORE;
                  state_in  = S_DONE;
               end else begin
                  seg_in   = seg_ff - NW'(1);
                  state_in = S_BWD_RD;
               end
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_seg_in    = seg_ff[ssl_pkg::SEGMENT_W-1:0];
               rsp_time_in   = t_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         loop_ff      <= 1'b0;
         count_ff     <= ssl_pkg::KEY_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loop_ff      <= loop_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      last_ff       <= last_in;
      seg_ff        <= seg_in;
      t_ff          <= t_in;
      begin_ff      <= begin_in;
      span_ff       <= span_in;
      neg_ff        <= neg_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_seg_ff    <= rsp_seg_in;
      rsp_time_ff   <= rsp_time_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = RSP_DW'({rsp_time_ff, rsp_seg_ff});

   a_mod_done_in_wrap : assert property (@(posedge clock) disable iff (reset)
      mod_done |-> (state_ff == S_WRAP))
      else $error("remainder finished outside the wrap step");

   a_cursor_in_range : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_FWD_CMP) || (state_ff == S_BWD_CMP)) |-> (seg_ff <= last_ff))
      else $error("cursor left the valid segments");

   a_query_starts : assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_tuser == ssl_pkg::CMD_QUERY)) |=> (state_ff == S_KEY0))
      else $error("query beat did not start a table read");

   a_write_stays_idle : assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_tuser == ssl_pkg::CMD_WRITE)) |=> (state_ff == S_IDLE))
      else $error("write beat left the idle state");

endmodule
